// ----- rtl/core/ipv6p_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ipv6p_pkg;

    localparam int ADDR_BYTES = 16;
    localparam int ADDR_W     = 8 * ADDR_BYTES;
    localparam int HALF_W     = ADDR_W / 2;
    localparam int CNT_W      = $clog2(ADDR_BYTES + 1);

    // Finished text, handed from the character parser to the address builder.
    // Both accumulators hold their bytes right-aligned, oldest byte highest.
    typedef struct packed {
        logic              ok;
        logic [CNT_W-1:0]  left_count;
        logic [ADDR_W-1:0] left_acc;
        logic [ADDR_W-1:0] right_acc;
    } fin_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipv6p_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ipv6p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface ipv6p_out_if;
    import ipv6p_pkg::*;

    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;

    modport source (output valid, output valid_res, output addr_high, output addr_low,
                    input ready);
    modport sink   (input valid, input valid_res, input addr_high, input addr_low,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ipv6_text_address_parser_top.sv -----
// Takes one character per cycle; back-to-back transfers are accepted with no bubbles.
// The result for a text passes through the parser-to-builder queue and is then held in
// the builder's output register, from which it can transfer.
// Input stalls only when QUEUE_DEPTH finished texts wait behind a stalled output.
// Asynchronous active-low reset clears the parser, queue and output valid; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_text_address_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ipv6p_in_if.sink     text,
    ipv6p_out_if.source  result
);
    import ipv6p_pkg::*;

    logic fin_push;
    logic fin_pop;
    logic fin_full;
    logic fin_empty;
    fin_t fin_wr;
    fin_t fin_rd;

    ipv6p_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .queue_full (fin_full),
        .fin_push   (fin_push),
        .fin        (fin_wr)
    );

    ipv6p_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(fin_t))
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fin_push),
        .wr_data (fin_wr),
        .full    (fin_full),
        .rd_en   (fin_pop),
        .rd_data (fin_rd),
        .empty   (fin_empty)
    );

    ipv6p_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_empty (fin_empty),
        .fin       (fin_rd),
        .fin_pop   (fin_pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ipv6p_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipv6p_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipv6p_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipv6p_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ipv6p_in_if.sink      text,
    input  wire logic     queue_full,
    output logic          fin_push,
    output ipv6p_pkg::fin_t fin
);
    import ipv6p_pkg::*;

    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_COLON = 2'd1,
        SEP_DOT   = 2'd2
    } sep_t;

    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [2:0] MAX_DIGITS = 3'd4;
    localparam int         SUM_W      = CNT_W + 1;

    logic [ADDR_W-1:0] left_reg, left_next;
    logic [ADDR_W-1:0] right_reg, right_next;
    logic [CNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [CNT_W-1:0]  rcnt_reg, rcnt_next;
    logic              side_reg, side_next;
    sep_t              sep_reg, sep_next;
    logic [15:0]       hex_reg, hex_next;
    logic [13:0]       dec_reg, dec_next;
    logic [2:0]        ndig_reg, ndig_next;
    logic              letter_reg, letter_next;
    logic [CNT_W-1:0]  dots_reg, dots_next;
    logic              err_reg, err_next;

    logic              accept;
    logic              is_num, is_lower, is_upper, is_hex, is_letter;
    logic [3:0]        dval;
    logic              push_word, push_dot;
    logic [SUM_W-1:0]  total;

    assign text.ready = !queue_full;
    assign accept     = text.valid && text.ready;
    assign fin_push   = accept && text.is_end;

    // classify the character
    always_comb
    begin
        is_num    = (text.ch >= 8'h30) && (text.ch <= 8'h39);
        is_lower  = (text.ch >= 8'h61) && (text.ch <= 8'h66);
        is_upper  = (text.ch >= 8'h41) && (text.ch <= 8'h46);
        is_letter = is_lower || is_upper;
        is_hex    = is_num || is_letter;
        dval      = is_num ? text.ch[3:0] : (text.ch[3:0] + 4'd9);
    end

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        lcnt_next   = lcnt_reg;
        rcnt_next   = rcnt_reg;
        side_next   = side_reg;
        sep_next    = sep_reg;
        hex_next    = hex_reg;
        dec_next    = dec_reg;
        ndig_next   = ndig_reg;
        letter_next = letter_reg;
        dots_next   = dots_reg;
        err_next    = err_reg;
        push_word   = 1'b0;
        push_dot    = 1'b0;
        total       = SUM_W'(lcnt_reg) + SUM_W'(rcnt_reg);

        if (accept && !err_reg)
        begin
            if (text.is_end)
            begin
                // close the last group
                if (ndig_reg != '0)
                begin
                    unique case (sep_reg)
                        SEP_COLON: push_word = 1'b1;
                        SEP_DOT:   push_dot  = 1'b1;
                        default:   err_next  = 1'b1;
                    endcase
                end
            end
            else if (is_hex)
            begin
                if ((is_letter && sep_reg == SEP_DOT) || ndig_reg >= MAX_DIGITS)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    hex_next  = {hex_reg[11:0], dval};
                    ndig_next = ndig_reg + 1'b1;
                    if (is_letter)
                    begin
                        letter_next = 1'b1;
                    end
                    else
                    begin
                        dec_next = 14'(({3'b0, dec_reg} << 3) + ({3'b0, dec_reg} << 1)
                                       + 17'(dval));
                    end
                end
            end
            else if (text.ch == CH_COLON)
            begin
                if (ndig_reg != '0)
                begin
                    if (sep_reg == SEP_DOT)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        push_word = 1'b1;
                        sep_next  = SEP_COLON;
                    end
                end
                else if (sep_reg == SEP_COLON)
                begin
                    if (rcnt_reg == '0)
                    begin
                        side_next = 1'b1;
                        sep_next  = SEP_COLON;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    sep_next = SEP_COLON;
                end
            end
            else if (text.ch == CH_DOT)
            begin
                if (ndig_reg == '0)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    push_dot = 1'b1;
                    sep_next = SEP_DOT;
                end
            end
            else
            begin
                err_next = 1'b1;
            end
        end

        if (push_word || push_dot)
        begin
            hex_next    = '0;
            dec_next    = '0;
            ndig_next   = '0;
            letter_next = 1'b0;
        end

        if (push_word)
        begin
            if (total > SUM_W'(ADDR_BYTES - 2))
            begin
                err_next = 1'b1;
            end
            else if (side_reg)
            begin
                right_next = {right_reg[ADDR_W-17:0], hex_reg};
                rcnt_next  = rcnt_reg + CNT_W'(2);
            end
            else
            begin
                left_next = {left_reg[ADDR_W-17:0], hex_reg};
                lcnt_next = lcnt_reg + CNT_W'(2);
            end
        end

        if (push_dot)
        begin
            dots_next = dots_reg + 1'b1;
            if (letter_reg || total >= SUM_W'(ADDR_BYTES))
            begin
                err_next = 1'b1;
            end
            else if (side_reg)
            begin
                right_next = {right_reg[ADDR_W-9:0], dec_reg[7:0]};
                rcnt_next  = rcnt_reg + 1'b1;
            end
            else
            begin
                left_next = {left_reg[ADDR_W-9:0], dec_reg[7:0]};
                lcnt_next = lcnt_reg + 1'b1;
            end
        end
    end

    // final checks on the closing transfer
    always_comb
    begin
        fin.ok = !err_next
                 && (dots_next == '0 || dots_next == CNT_W'(4))
                 && (side_reg
                     || (SUM_W'(lcnt_next) + SUM_W'(rcnt_next) == SUM_W'(ADDR_BYTES)));
        fin.left_count = lcnt_next;
        fin.left_acc   = left_next;
        fin.right_acc  = right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            lcnt_reg   <= '0;
            rcnt_reg   <= '0;
            side_reg   <= 1'b0;
            sep_reg    <= SEP_NONE;
            hex_reg    <= '0;
            dec_reg    <= '0;
            ndig_reg   <= '0;
            letter_reg <= 1'b0;
            dots_reg   <= '0;
            err_reg    <= 1'b0;
        end
        else if (fin_push)
        begin
            // start the next text from scratch
            left_reg   <= '0;
            right_reg  <= '0;
            lcnt_reg   <= '0;
            rcnt_reg   <= '0;
            side_reg   <= 1'b0;
            sep_reg    <= SEP_NONE;
            hex_reg    <= '0;
            dec_reg    <= '0;
            ndig_reg   <= '0;
            letter_reg <= 1'b0;
            dots_reg   <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            lcnt_reg   <= lcnt_next;
            rcnt_reg   <= rcnt_next;
            side_reg   <= side_next;
            sep_reg    <= sep_next;
            hex_reg    <= hex_next;
            dec_reg    <= dec_next;
            ndig_reg   <= ndig_next;
            letter_reg <= letter_next;
            dots_reg   <= dots_next;
            err_reg    <= err_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipv6p_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipv6p_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fin_empty,
    input  ipv6p_pkg::fin_t fin,
    output logic            fin_pop,
    ipv6p_out_if.source     result
);
    import ipv6p_pkg::*;

    logic              out_valid_reg;
    logic              res_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [CNT_W-1:0]  gap_bytes;

    assign fin_pop = !fin_empty && (!out_valid_reg || result.ready);

    // move the left side to the front; the right side already sits at the far end
    always_comb
    begin
        gap_bytes = CNT_W'(ADDR_BYTES) - fin.left_count;
        addr_next = fin.ok ? ((fin.left_acc << {gap_bytes, 3'b000}) | fin.right_acc) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_pop)
        begin
            res_ok_reg <= fin.ok;
            addr_reg   <= addr_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.valid_res = res_ok_reg;
    assign result.addr_high = addr_reg[ADDR_W-1:HALF_W];
    assign result.addr_low  = addr_reg[HALF_W-1:0];

endmodule

`default_nettype wire
